// ----- rtl/core/sha1_message_digest_macros.svh -----
// assertion helpers for the sha1 digest core
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SHA1MD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sha1md assertion failed");

// antecedent implies consequent in the next cycle
`define SHA1MD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sha1md assertion failed");

`endif

// ----- rtl/core/sha1md_pkg.sv -----
package sha1md_pkg;

  localparam int unsigned IN_W  = 40;
  localparam int unsigned OUT_W = 160;

  typedef logic [31:0] word_t;

  localparam word_t K0 = 32'h5a82_7999;
  localparam word_t K1 = 32'h6ed9_eba1;
  localparam word_t K2 = 32'h8f1b_bcdc;
  localparam word_t K3 = 32'hca62_c1d6;

  localparam word_t H0_INIT = 32'h6745_2301;
  localparam word_t H1_INIT = 32'hefcd_ab89;
  localparam word_t H2_INIT = 32'h98ba_dcfe;
  localparam word_t H3_INIT = 32'h1032_5476;
  localparam word_t H4_INIT = 32'hc3d2_e1f0;

  localparam word_t MARKER_WORD = 32'h8000_0000;

  // keep the top cnt bytes of a short last word and place the marker byte below them
  function automatic word_t pad_word(input word_t data, input logic [1:0] cnt);
    word_t res;
    case (cnt)
      2'd0:    res = MARKER_WORD;
      2'd1:    res = {data[31:24], 24'h80_0000};
      2'd2:    res = {data[31:16], 16'h8000};
      2'd3:    res = {data[31:8], 8'h80};
      default: res = data;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/core/sha1_message_digest.sv -----
// sha1 digest core
// input stream: one big-endian 32-bit message word per transfer, first byte in
// bits 31:24. tdata carries the word and its valid byte count, tlast marks the
// final word of a message. only the last word may be short (count 0..3); a
// count above four is taken as four.
// output stream: one 160-bit digest per message, h0 in the low 32 bits.
// timing: a word is taken whenever tready is high. each 16th word starts a
// compression of 80 rounds, one per cycle through a single round adder, plus
// a final add into the chaining value; tready stays low from that word until
// the add is done. after the last word the padding and length words are
// shifted in at one per cycle, pausing while a compression runs whenever the
// block fills, and one or two compressions run in all before the digest
// appears. tready is low while padding or compressing.
// the digest sits in an output register, so a new message can stream in while
// it waits; only if a second digest finishes before the first is taken does
// the core hold in its final add cycle until m_axis_tready.
// reset: chaining value back to the initial constants, counters cleared,
// output empty.
module sha1_message_digest (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sha1md_pkg::IN_W-1:0]   s_axis_tdata,   // data_word, byte_count, zero fill
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sha1md_pkg::OUT_W-1:0]  m_axis_tdata    // digest_h0 .. digest_h4
);
  import sha1md_pkg::*;
  `include "sha1_message_digest_macros.svh"

  typedef enum logic [1:0] {ST_IDLE, ST_PAD, ST_ROUND, ST_FINAL} state_e;

  state_e      state_q;
  word_t       h_q [5];
  word_t       a_q, b_q, c_q, d_q, e_q;
  word_t       w_q [16];
  logic [3:0]  pos_q;
  logic [63:0] bitcnt_q;
  logic [6:0]  round_q;
  logic        pad_q, mark_q, len_q, final_q;
  logic        out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  logic        accept;
  word_t       in_word;
  logic [2:0]  in_cnt;
  logic        in_full;
  logic [2:0]  cnt_sat;
  logic        push_en;
  word_t       push_word;
  logic        block_full;
  logic        load_out;
  word_t       f_val, k_val, t_val, w_new;
  word_t       sum [5];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign in_word = s_axis_tdata[31:0];
  assign in_cnt  = s_axis_tdata[34:32];
  assign in_full = in_cnt[2];
  assign cnt_sat = in_full ? 3'd4 : in_cnt;

  // word to shift into the block store this cycle
  always_comb begin
    push_en   = 1'b0;
    push_word = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          push_en = 1'b1;
          if (s_axis_tlast && !in_full) push_word = pad_word(in_word, in_cnt[1:0]);
          else push_word = in_word;
        end
      end
      ST_PAD: begin
        push_en = 1'b1;
        if (mark_q) push_word = MARKER_WORD;
        else if (pos_q < 4'd14) push_word = '0;
        else if (pos_q == 4'd14) push_word = bitcnt_q[63:32];
        else push_word = len_q ? bitcnt_q[31:0] : '0;
      end
      default: begin
        push_en   = 1'b0;
        push_word = '0;
      end
    endcase
  end

  assign block_full = push_en && (pos_q == 4'hf);
  assign load_out   = (state_q == ST_FINAL) && final_q && (!out_valid_q || m_axis_tready);

  // round function; w_q[0] is the schedule word of the current round
  always_comb begin
    if (round_q < 7'd20) begin
      f_val = (b_q & c_q) | (~b_q & d_q);
      k_val = K0;
    end else if (round_q < 7'd40) begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K1;
    end else if (round_q < 7'd60) begin
      f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_val = K2;
    end else begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K3;
    end
    t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + w_q[0] + k_val;
    w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    w_new = {w_new[30:0], w_new[31]};
    sum[0] = h_q[0] + a_q;
    sum[1] = h_q[1] + b_q;
    sum[2] = h_q[2] + c_q;
    sum[3] = h_q[3] + d_q;
    sum[4] = h_q[4] + e_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      h_q[0]      <= H0_INIT;
      h_q[1]      <= H1_INIT;
      h_q[2]      <= H2_INIT;
      h_q[3]      <= H3_INIT;
      h_q[4]      <= H4_INIT;
      pos_q       <= '0;
      bitcnt_q    <= '0;
      round_q     <= '0;
      pad_q       <= 1'b0;
      mark_q      <= 1'b0;
      len_q       <= 1'b0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;

      // block store is a shift line: oldest word at index 0
      if (push_en || state_q == ST_ROUND) begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= push_en ? push_word : w_new;
      end
      if (push_en) pos_q <= pos_q + 4'd1;

      if (block_full) begin
        a_q     <= h_q[0];
        b_q     <= h_q[1];
        c_q     <= h_q[2];
        d_q     <= h_q[3];
        e_q     <= h_q[4];
        round_q <= '0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (s_axis_tlast) begin
              bitcnt_q <= bitcnt_q + {58'd0, cnt_sat, 3'd0};
              pad_q    <= 1'b1;
              mark_q   <= in_full;
            end else begin
              bitcnt_q <= bitcnt_q + 64'd32;
            end
            if (block_full) state_q <= ST_ROUND;
            else if (s_axis_tlast) state_q <= ST_PAD;
          end
        end
        ST_PAD: begin
          if (mark_q) mark_q <= 1'b0;
          else if (pos_q == 4'd14) len_q <= 1'b1;
          else if (pos_q == 4'hf && len_q) final_q <= 1'b1;
          if (block_full) state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          e_q     <= d_q;
          d_q     <= c_q;
          c_q     <= {b_q[1:0], b_q[31:2]};
          b_q     <= a_q;
          a_q     <= t_val;
          round_q <= round_q + 7'd1;
          if (round_q == 7'd79) state_q <= ST_FINAL;
        end
        ST_FINAL: begin
          if (final_q) begin
            // wait for the output register to free up
            if (load_out) begin
              out_data_q  <= {sum[4], sum[3], sum[2], sum[1], sum[0]};
              h_q[0]      <= H0_INIT;
              h_q[1]      <= H1_INIT;
              h_q[2]      <= H2_INIT;
              h_q[3]      <= H3_INIT;
              h_q[4]      <= H4_INIT;
              bitcnt_q    <= '0;
              pad_q       <= 1'b0;
              len_q       <= 1'b0;
              final_q     <= 1'b0;
              state_q     <= ST_IDLE;
            end
          end else begin
            for (int i = 0; i < 5; i++) h_q[i] <= sum[i];
            state_q <= pad_q ? ST_PAD : ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `SHA1MD_ASSERT_IMPL(a_round_range, state_q == ST_ROUND, round_q < 7'd80)
  `SHA1MD_ASSERT_IMPL(a_block_aligned, state_q == ST_ROUND || state_q == ST_FINAL, pos_q == 4'd0)
  `SHA1MD_ASSERT_IMPL(a_idle_clean, state_q == ST_IDLE, !pad_q && !len_q && !final_q && !mark_q)
  `SHA1MD_ASSERT_NEXT(a_digest_load, load_out, m_axis_tvalid && bitcnt_q == 64'd0 && state_q == ST_IDLE)

endmodule
